@@ rtl/itha_pkg.sv @@
// Package: allocator constants, record type and controller states.
package itha_pkg;
	localparam int HEAP_BYTES  = 65536;
	localparam int MAX_RECORDS = 256;
	localparam int IW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam int HW = $clog2(HEAP_BYTES + 1);
	localparam int OW = 16;
	localparam int SW = 17;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_REALLOC = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_HEAP_FULL = 2'd1;
	localparam logic [1:0] ST_IDX_FULL  = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic          in_use;
		logic [SW-1:0] size;
		logic [OW-1:0] offset;
	} rec_t;

	typedef enum logic [2:0] {
		S_IDLE, S_ROUND, S_FIND, S_FREE, S_ASCAN, S_AWRITE, S_FIN
	} state_t;
endpackage

@@ rtl/itha_cell.sv @@
// One record cell of the rotating record ring.
module itha_cell (
	input  logic         clk,
	input  logic         shift,
	input  itha_pkg::rec_t d,
	output itha_pkg::rec_t q
);
	import itha_pkg::*;
	rec_t rec_q;
	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= d;
		end
	end
	assign q = rec_q;
endmodule

@@ rtl/itha_round.sv @@
// Bit-serial remainder unit that rounds a request up to the granularity.
module itha_round (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] req,
	input  logic [8:0]  gran,
	output logic        done,
	output logic [itha_pkg::SW-1:0] size
);
	import itha_pkg::*;
	logic [15:0] num_q;
	logic [15:0] szv_q;
	logic [8:0]  rem_q;
	logic [8:0]  g_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [9:0]  t;

	assign t = {rem_q, num_q[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'd16;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= (req == 16'd0) ? 16'd1 : req;
			szv_q <= (req == 16'd0) ? 16'd1 : req;
			rem_q <= '0;
			g_q   <= (gran == 9'd0) ? 9'd1 : gran;
		end else if (busy_q) begin
			num_q <= {num_q[14:0], 1'b0};
			if (t >= {1'b0, g_q}) begin
				rem_q <= 9'(t - {1'b0, g_q});
			end else begin
				rem_q <= t[8:0];
			end
		end
	end

	assign done = done_q;
	assign size = (rem_q == 9'd0) ? {1'b0, szv_q}
		: SW'({1'b0, szv_q} + {8'd0, g_q} - {8'd0, rem_q});
endmodule

@@ rtl/index_table_heap_allocator_top.sv @@
// Top level: heap allocator controller over a rotating ring of record cells.
//
// Records sit in a ring of MAX_RECORDS cells that rotates by one cell per cycle during a
// pass, so every record passes the head cell once per pass. Alloc takes a rounding step,
// one scan pass and one write pass; a failing alloc skips the write pass. Free takes a
// lookup pass and a free-and-trim pass; realloc takes four passes; a lookup that misses
// ends the command. A free or realloc at an offset at or above the heap top and command
// 3 go straight to the result state. One command is worked at a time; a new command is
// taken while the previous result waits at the output. No clearing pass after reset.
module index_table_heap_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // cmd[1:0], req_size[17:2], block_offset[33:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // status[1:0], result_offset[17:2], copy_length[33:18],
	                               // heap_used[50:34], records_used[59:51]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data   // granularity
);
	import itha_pkg::*;

	state_t state_q, state_d;
	logic [8:0]    gran_q;
	logic [1:0]    cmd_q;
	logic [OW-1:0] boff_q;
	logic [HW-1:0] heap_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] k_q;
	logic          last_k;
	logic          k_live;
	logic          shift;
	rec_t          cq [MAX_RECORDS];
	rec_t          head_mod;

	logic          found_q;
	logic [IW-1:0] idx_q;
	logic [SW-1:0] old_q;
	logic          have_use_q;
	logic [IW-1:0] lastuse_q;
	logic [OW-1:0] trim_off_q;
	logic          have_q, exact_q;
	logic [IW-1:0] best_q;
	logic [SW-1:0] bsize_q;
	logic [OW-1:0] boffc_q;
	logic [IW-1:0] tgt_q;
	rec_t          wrec_q;
	logic [1:0]    st_q;
	logic [OW-1:0] roff_q;
	logic [15:0]   copy_q;
	logic          out_v_q;
	logic [63:0]   out_q;

	logic          rnd_start, rnd_done;
	logic [SW-1:0] nsz;
	logic          accept;
	logic          eff_use;
	logic          cur_use;
	logic          trim_cur;
	logic [OW-1:0] trim_off;
	logic [CW-1:0] new_count;
	logic [SW-1:0] cmin;
	logic          fin_go;
	logic          scan_hit;
	logic          scan_fail;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign shift     = (state_q == S_FIND) || (state_q == S_FREE)
		|| (state_q == S_ASCAN) || (state_q == S_AWRITE);
	assign last_k    = (k_q == IW'(MAX_RECORDS - 1));
	assign k_live    = ({1'b0, k_q} < count_q);
	assign rnd_start = accept && (s_tdata[1:0] == CMD_ALLOC || s_tdata[1:0] == CMD_REALLOC);
	assign eff_use   = cq[0].in_use && !(k_q == idx_q);
	assign fin_go    = !out_v_q || m_tready;
	assign cur_use   = k_live && eff_use;
	assign trim_cur  = k_live && !eff_use && ((!have_use_q && k_q == '0)
		|| (have_use_q && {1'b0, k_q} == {1'b0, lastuse_q} + 1'b1));
	assign trim_off  = trim_cur ? cq[0].offset : trim_off_q;
	assign new_count = cur_use ? CW'({1'b0, k_q} + 1'b1)
		: (have_use_q ? CW'({1'b0, lastuse_q} + 1'b1) : '0);
	assign cmin      = (old_q < nsz) ? old_q : nsz;
	assign scan_hit  = have_q || exact_q || (k_live && !cq[0].in_use && nsz <= cq[0].size);
	assign scan_fail = !scan_hit
		&& ((({1'b0, heap_q} + {1'b0, nsz}) > (HW+1)'(HEAP_BYTES))
		|| (count_q >= CW'(MAX_RECORDS)));

	itha_round u_round (
		.clk(clk), .arst_n(arst_n), .start(rnd_start), .req(s_tdata[17:2]),
		.gran(gran_q), .done(rnd_done), .size(nsz)
	);

	always_comb begin
		head_mod = cq[0];
		if (state_q == S_AWRITE && k_q == tgt_q) begin
			head_mod = wrec_q;
		end else if (state_q == S_FREE && k_q == idx_q) begin
			head_mod.in_use = 1'b0;
		end
	end

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_ring
		itha_cell u_cell (
			.clk(clk), .shift(shift),
			.d((i == MAX_RECORDS - 1) ? head_mod : cq[(i + 1) % MAX_RECORDS]),
			.q(cq[i])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (s_tdata[1:0])
						CMD_ALLOC: state_d = S_ROUND;
						CMD_FREE, CMD_REALLOC: begin
							if ({1'b0, s_tdata[33:18]} >= heap_q) begin
								state_d = S_FIN;
							end else begin
								state_d = S_FIND;
							end
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_ROUND: if (rnd_done) state_d = S_ASCAN;
			S_FIND: begin
				if (last_k) begin
					state_d = (found_q || (k_live && cq[0].offset == boff_q)) ? S_FREE : S_FIN;
				end
			end
			S_FREE: if (last_k) state_d = (cmd_q == CMD_FREE) ? S_FIN : S_ROUND;
			S_ASCAN: begin
				if (last_k) state_d = scan_fail ? S_FIN : S_AWRITE;
			end
			S_AWRITE: if (last_k) state_d = S_FIN;
			S_FIN: if (fin_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gran_q  <= 9'd8;
			heap_q  <= '0;
			count_q <= '0;
			k_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) gran_q <= cfg_data;
			if (shift) k_q <= last_k ? '0 : IW'(k_q + 1'b1);
			if (state_q == S_FIN && fin_go) begin
				out_v_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_v_q <= 1'b0;
			end
			if (state_q == S_FREE && last_k) begin
				count_q <= new_count;
				if (new_count != count_q) heap_q <= {1'b0, trim_off};
			end
			if (state_q == S_ASCAN && last_k && !have_q && !exact_q
				&& !(k_live && !cq[0].in_use && nsz <= cq[0].size)
				&& !(({1'b0, heap_q} + {1'b0, nsz}) > (HW+1)'(HEAP_BYTES))
				&& (count_q < CW'(MAX_RECORDS))) begin
				heap_q  <= HW'(heap_q + nsz);
				count_q <= CW'(count_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_tdata[1:0];
			boff_q  <= s_tdata[33:18];
			found_q <= 1'b0;
			idx_q   <= '0;
			copy_q  <= '0;
			if ((s_tdata[1:0] == CMD_FREE || s_tdata[1:0] == CMD_REALLOC)
				&& {1'b0, s_tdata[33:18]} >= heap_q) begin
				st_q   <= ST_NOT_FOUND;
				roff_q <= s_tdata[33:18];
			end else begin
				st_q   <= ST_OK;
				roff_q <= '0;
			end
		end
		case (state_q)
			S_FIND: begin
				if (k_q == '0) begin
					have_use_q <= 1'b0;
					lastuse_q  <= '0;
				end
				if (!found_q && k_live && cq[0].offset == boff_q) begin
					found_q <= 1'b1;
					idx_q   <= k_q;
					old_q   <= cq[0].size;
				end
				if (last_k && !(found_q || (k_live && cq[0].offset == boff_q))) begin
					st_q   <= ST_NOT_FOUND;
					roff_q <= boff_q;
				end
			end
			S_FREE: begin
				if (k_live) begin
					if (eff_use) begin
						have_use_q <= 1'b1;
						lastuse_q  <= k_q;
					end else if ((!have_use_q && k_q == '0)
						|| (have_use_q && {1'b0, k_q} == {1'b0, lastuse_q} + 1'b1)) begin
						trim_off_q <= cq[0].offset;
					end
				end
				if (last_k) begin
					roff_q  <= boff_q;
					have_q  <= 1'b0;
					exact_q <= 1'b0;
				end
			end
			S_ROUND: ;
			S_ASCAN: begin
				if (k_live && !cq[0].in_use && nsz <= cq[0].size && !exact_q) begin
					if (cq[0].size == nsz) begin
						exact_q <= 1'b1;
						have_q  <= 1'b1;
						best_q  <= k_q;
						bsize_q <= cq[0].size;
						boffc_q <= cq[0].offset;
					end else if (!have_q || bsize_q < cq[0].size) begin
						have_q  <= 1'b1;
						best_q  <= k_q;
						bsize_q <= cq[0].size;
						boffc_q <= cq[0].offset;
					end
				end
			end
			S_AWRITE: begin
				if (last_k) begin
					st_q   <= ST_OK;
					roff_q <= wrec_q.offset;
					if (cmd_q == CMD_REALLOC && wrec_q.offset != boff_q) begin
						copy_q <= (cmin > SW'(16'hFFFF)) ? 16'hFFFF : cmin[15:0];
					end
				end
			end
			S_FIN: begin
				if (fin_go) begin
					out_q <= {4'd0, count_q, heap_q, copy_q, roff_q, st_q};
				end
			end
			default: ;
		endcase
		if (state_q == S_IDLE && accept) begin
			have_q  <= 1'b0;
			exact_q <= 1'b0;
		end
		if (state_q == S_ASCAN && last_k) begin
			if (have_q || exact_q || (k_live && !cq[0].in_use && nsz <= cq[0].size)) begin
				if (k_live && !cq[0].in_use && nsz <= cq[0].size && !exact_q
					&& (cq[0].size == nsz || !have_q || bsize_q < cq[0].size)) begin
					tgt_q  <= k_q;
					wrec_q <= '{in_use: 1'b1, size: cq[0].size, offset: cq[0].offset};
				end else begin
					tgt_q  <= best_q;
					wrec_q <= '{in_use: 1'b1, size: bsize_q, offset: boffc_q};
				end
			end else if (({1'b0, heap_q} + {1'b0, nsz}) > (HW+1)'(HEAP_BYTES)) begin
				st_q   <= ST_HEAP_FULL;
				roff_q <= '0;
			end else if (count_q >= CW'(MAX_RECORDS)) begin
				st_q   <= ST_IDX_FULL;
				roff_q <= '0;
			end else begin
				tgt_q  <= count_q[IW-1:0];
				wrec_q <= '{in_use: 1'b1, size: nsz, offset: heap_q[OW-1:0]};
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	ascan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (k_q == '0))
		else $error("ring not aligned at idle");
	count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RECORDS))
		else $error("record count beyond table");
	heap_max: assert property (@(posedge clk) disable iff (!arst_n)
		heap_q <= HW'(HEAP_BYTES))
		else $error("heap top beyond heap");
endmodule
